// ===== rtl/hfs_pkg.sv =====
package hfs_pkg;

	localparam int DEF_PANEL_WIDTH  = 32;
	localparam int DEF_PANEL_HEIGHT = 16;
	localparam int DEF_SCAN_ROWS    = 8;
	localparam int MAX_SCAN_COLS    = 32;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_FILL  = 2'd1;
	localparam logic [1:0] MODE_SCAN  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCAN
	} seq_state_t;

	// Side information that travels with one column read
	typedef struct packed {
		logic [2:0] row_address;
		logic [4:0] column;
		logic       last;
		logic       upper_ok;
		logic       lower_ok;
	} scan_tag_t;

	// Keep the top bit of each RGB565 channel: red, green, blue
	function automatic logic [2:0] color_bits(input logic [15:0] c);
		color_bits = {c[15], c[10], c[4]};
	endfunction

endpackage

// ===== rtl/hfs_store.sv =====
module hfs_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [2:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_u,
	input  logic [AW-1:0] raddr_l,
	output logic [2:0]    rdata_u,
	output logic [2:0]    rdata_l
);

	logic [2:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data until the next read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_u <= mem[raddr_u];
			rdata_l <= mem[raddr_l];
		end
	end

endmodule

// ===== rtl/hfs_seq.sv =====
module hfs_seq #(
	parameter int PANEL_WIDTH  = hfs_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = hfs_pkg::DEF_PANEL_HEIGHT,
	parameter int SCAN_ROWS    = hfs_pkg::DEF_SCAN_ROWS,
	parameter int AW           = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic [15:0]        color,
	input  logic               can_issue,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [2:0]         wdata,
	output logic               re,
	output logic [AW-1:0]      raddr_u,
	output logic [AW-1:0]      raddr_l,
	output hfs_pkg::scan_tag_t tag
);

	import hfs_pkg::*;

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int NCOLS = (PANEL_WIDTH < MAX_SCAN_COLS) ? PANEL_WIDTH : MAX_SCAN_COLS;
	localparam int CW    = $clog2(NCOLS);
	localparam int SRW   = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
	localparam int RW    = $clog2(2 * SCAN_ROWS);
	localparam int XW    = $clog2(PANEL_WIDTH);
	localparam int YW    = $clog2(PANEL_HEIGHT);

	seq_state_t     state_q, state_d;
	logic [AW-1:0]  cnt_q;
	logic [CW-1:0]  col_q;
	logic [2:0]     fill_q;
	logic [SRW-1:0] scan_row_q;
	logic [AW-1:0]  ubase_q, lbase_q;
	logic           uok_q, lok_q;
	logic [2:0]     rowaddr_q;

	logic           on_panel;
	logic [AW-1:0]  pix_addr;
	logic [SRW-1:0] scan_row_d;
	logic [RW-1:0]  top_half_row, bot_half_row;
	logic           take;
	logic           col_end;

	assign on_panel = !x[15] && !y[15] && (x < 16'(PANEL_WIDTH)) && (y < 16'(PANEL_HEIGHT));
	assign pix_addr = AW'(32'(y[YW-1:0]) * PANEL_WIDTH + 32'(x[XW-1:0]));

	assign scan_row_d   = (scan_row_q == SRW'(SCAN_ROWS - 1)) ? '0 : scan_row_q + 1'b1;
	assign top_half_row = RW'(SCAN_ROWS - 1) - RW'(scan_row_d);
	assign bot_half_row = top_half_row + RW'(SCAN_ROWS);

	assign take    = in_valid && in_ready;
	assign col_end = (col_q == CW'(NCOLS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR, ST_FILL: begin
				if (cnt_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && mode == MODE_FILL) state_d = ST_FILL;
				else if (in_valid && mode == MODE_SCAN) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (can_issue && col_end) state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = pix_addr;
		wdata    = color_bits(color);
		re       = 1'b0;
		unique case (state_q)
			ST_CLEAR, ST_FILL: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = fill_q;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				we       = in_valid && mode == MODE_WRITE && on_panel;
			end
			ST_SCAN: begin
				re = can_issue;
			end
		endcase
	end

	assign raddr_u = ubase_q + AW'(col_q);
	assign raddr_l = lbase_q + AW'(col_q);

	assign tag.row_address = rowaddr_q;
	assign tag.column      = 5'(col_q);
	assign tag.last        = col_end;
	assign tag.upper_ok    = uok_q;
	assign tag.lower_ok    = lok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			col_q      <= '0;
			fill_q     <= '0;
			scan_row_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_FILL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_SCAN && can_issue) begin
				col_q <= col_q + 1'b1;
			end
			if (take) begin
				cnt_q <= '0;
				col_q <= '0;
				if (mode == MODE_FILL) fill_q <= color_bits(color);
				if (mode == MODE_SCAN) scan_row_q <= scan_row_d;
			end
		end
	end

	// Latch the row pair of a scan at its start
	always_ff @(posedge clk) begin
		if (take && mode == MODE_SCAN) begin
			ubase_q   <= AW'(32'(top_half_row) * PANEL_WIDTH);
			lbase_q   <= AW'(32'(bot_half_row) * PANEL_WIDTH);
			uok_q     <= 32'(top_half_row) < PANEL_HEIGHT;
			lok_q     <= 32'(bot_half_row) < PANEL_HEIGHT;
			rowaddr_q <= 3'(32'(top_half_row));
		end
	end

endmodule

// ===== rtl/hub75_framebuffer_scan.sv =====
// Frame buffer and row scan for a HUB75 panel, one bit per color. A pixel write
// (mode 0) keeps the block idle; an item can be accepted every cycle. A fill (mode 1)
// sweeps all PANEL_WIDTH*PANEL_HEIGHT entries of the pixel memory, one per cycle,
// during which no item is accepted. A scan (mode 2) advances the row counter and
// reads the upper and lower pixel of one column per cycle from the dual-read memory,
// giving min(PANEL_WIDTH, 32) words at one per cycle while out_ready stays high; the
// next item is accepted once the last column read is issued. After reset the block
// clears the memory with the same sweep over all PANEL_WIDTH*PANEL_HEIGHT entries
// (512 at the defaults) before in_ready first rises.
module hub75_framebuffer_scan #(
	parameter int PANEL_WIDTH  = hfs_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = hfs_pkg::DEF_PANEL_HEIGHT,
	parameter int SCAN_ROWS    = hfs_pkg::DEF_SCAN_ROWS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic [15:0]        color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         row_address,
	output logic [4:0]         column,
	output logic               upper_red,
	output logic               upper_green,
	output logic               upper_blue,
	output logic               lower_red,
	output logic               lower_green,
	output logic               lower_blue,
	output logic               last
);

	import hfs_pkg::*;

	localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic          we, re, can_issue, move;
	logic [AW-1:0] waddr, raddr_u, raddr_l;
	logic [2:0]    wdata, rdata_u, rdata_l;
	scan_tag_t     tag, tag_s1;
	logic          v_s1;

	logic          out_valid_q;
	logic [2:0]    row_address_q;
	logic [4:0]    column_q;
	logic [2:0]    upper_q, lower_q;
	logic          last_q;

	hfs_seq #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.SCAN_ROWS   (SCAN_ROWS),
		.AW          (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.x        (x),
		.y        (y),
		.color    (color),
		.can_issue(can_issue),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (re),
		.raddr_u  (raddr_u),
		.raddr_l  (raddr_l),
		.tag      (tag)
	);

	hfs_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr_u(raddr_u),
		.raddr_l(raddr_l),
		.rdata_u(rdata_u),
		.rdata_l(rdata_l)
	);

	// Advance the read stage into the output register when it is free
	assign move      = v_s1 && (!out_valid_q || out_ready);
	assign can_issue = !v_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (re) v_s1 <= 1'b1;
			else if (move) v_s1 <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			tag_s1 <= tag;
		end
		if (move) begin
			row_address_q <= tag_s1.row_address;
			column_q      <= tag_s1.column;
			last_q        <= tag_s1.last;
			// Drop rows that lie past the panel
			upper_q       <= rdata_u & {3{tag_s1.upper_ok}};
			lower_q       <= rdata_l & {3{tag_s1.lower_ok}};
		end
	end

	assign out_valid   = out_valid_q;
	assign row_address = row_address_q;
	assign column      = column_q;
	assign upper_red   = upper_q[2];
	assign upper_green = upper_q[1];
	assign upper_blue  = upper_q[0];
	assign lower_red   = lower_q[2];
	assign lower_green = lower_q[1];
	assign lower_blue  = lower_q[0];
	assign last        = last_q;

endmodule
